// File: rtl/imu_urp_pkg.sv
package imu_urp_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned NUM_WORDS  = 10;
  // only the first twenty data bytes ever reach a result word
  localparam int unsigned WORD_BYTES = 2 * NUM_WORDS;
  localparam int unsigned POS_IDX_W  = $clog2(WORD_BYTES);
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned STATUS_W   = 3;

  localparam logic [DATA_W-1:0] READ_ACK_RST  = 8'd187;
  localparam logic [DATA_W-1:0] WRITE_HDR_RST = 8'd238;
  localparam logic [DATA_W-1:0] WRITE_OK_RST  = 8'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE      = 2'd0,
    CMD_ARM_READ  = 2'd1,
    CMD_ARM_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READ_ACK  = 2'd0,
    CFG_WRITE_HDR = 2'd1,
    CFG_WRITE_OK  = 2'd2
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE       = 3'd0,
    ST_BUSY       = 3'd1,
    ST_READ_DONE  = 3'd2,
    ST_WRITE_DONE = 3'd3,
    ST_ERROR      = 3'd4
  } status_e;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_HEADER = 7'b0000010,
    PH_LENGTH = 7'b0000100,
    PH_DATA   = 7'b0001000,
    PH_RESULT = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_ERROR  = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [DATA_W-1:0] read_ack;
    logic [DATA_W-1:0] write_hdr;
    logic [DATA_W-1:0] write_ok;
  } cfg_t;

  typedef struct packed {
    status_e                             status;
    logic [NUM_WORDS-1:0][WORD_W-1:0]    words;
  } result_t;

  function automatic status_e status_of(phase_e ph, logic is_read);
    status_e st;
    unique case (ph)
      PH_IDLE:  st = ST_IDLE;
      PH_DONE:  st = is_read ? ST_READ_DONE : ST_WRITE_DONE;
      PH_ERROR: st = ST_ERROR;
      default:  st = ST_BUSY;
    endcase
    return st;
  endfunction

endpackage

// File: rtl/imu_urp_if.sv
interface imu_urp_in_if import imu_urp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface imu_urp_cfg_if import imu_urp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface imu_urp_out_if import imu_urp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [WORD_W-1:0]   gyro_x;
  logic signed [WORD_W-1:0]   gyro_y;
  logic signed [WORD_W-1:0]   gyro_z;
  logic signed [WORD_W-1:0]   heading;
  logic signed [WORD_W-1:0]   roll;
  logic signed [WORD_W-1:0]   pitch;
  logic signed [WORD_W-1:0]   quat_w;
  logic signed [WORD_W-1:0]   quat_x;
  logic signed [WORD_W-1:0]   quat_y;
  logic signed [WORD_W-1:0]   quat_z;

  modport source (output valid, output status, output gyro_x, output gyro_y, output gyro_z,
                  output heading, output roll, output pitch, output quat_w, output quat_x,
                  output quat_y, output quat_z, input ready);
  modport sink   (input valid, input status, input gyro_x, input gyro_y, input gyro_z,
                  input heading, input roll, input pitch, input quat_w, input quat_x,
                  input quat_y, input quat_z, output ready);
endinterface

// File: rtl/imu_urp_cfg.sv
module imu_urp_cfg import imu_urp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  imu_urp_cfg_if.sink   cfg_i,
  output cfg_t          cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_READ_ACK:  cfg_d.read_ack  = cfg_i.data;
        CFG_WRITE_HDR: cfg_d.write_hdr = cfg_i.data;
        CFG_WRITE_OK:  cfg_d.write_ok  = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.read_ack  <= READ_ACK_RST;
      cfg_q.write_hdr <= WRITE_HDR_RST;
      cfg_q.write_ok  <= WRITE_OK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  a_cfg_ack_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && cfg_idx_e'(cfg_i.index) == CFG_READ_ACK |=> cfg_q.read_ack == $past(cfg_i.data))
    else $error("read ack code not taken from the write");

  a_cfg_bad_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && cfg_i.index == 2'd3 |=> $stable(cfg_q))
    else $error("write beyond the register list changed a register");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr |=> $stable(cfg_q))
    else $error("register changed without a write");

endmodule

// File: rtl/imu_urp_parse.sv
module imu_urp_parse import imu_urp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [DATA_W-1:0] rx_byte_i,
  input  cfg_t              cfg_i,
  output result_t           result_o
);

  phase_e                            phase_q, phase_d;
  logic                              is_read_q, is_read_d;
  logic [DATA_W-1:0]                 bytes_left_q, bytes_left_d;
  logic [DATA_W-1:0]                 write_pos_q, write_pos_d;
  logic [WORD_BYTES-1:0][DATA_W-1:0] store_q, store_d;
  status_e                           status_d;

  always_comb begin
    phase_d      = phase_q;
    is_read_d    = is_read_q;
    bytes_left_d = bytes_left_q;
    write_pos_d  = write_pos_q;
    store_d      = store_q;
    if (take_i) begin
      unique case (cmd_e'(cmd_i))
        CMD_BYTE: begin
          unique case (phase_q)
            PH_HEADER: begin
              if (is_read_q) begin
                phase_d = (rx_byte_i == cfg_i.read_ack) ? PH_LENGTH : PH_ERROR;
              end else begin
                phase_d = (rx_byte_i == cfg_i.write_hdr) ? PH_RESULT : PH_ERROR;
              end
            end
            PH_LENGTH: begin
              // a length of zero wraps on the first decrement, so 256 data bytes are taken
              bytes_left_d = rx_byte_i;
              write_pos_d  = '0;
              phase_d      = PH_DATA;
            end
            PH_DATA: begin
              // drop bytes that land past the unpacked words
              if (write_pos_q < DATA_W'(WORD_BYTES)) begin
                store_d[write_pos_q[POS_IDX_W-1:0]] = rx_byte_i;
              end
              write_pos_d  = write_pos_q + 8'd1;
              bytes_left_d = bytes_left_q - 8'd1;
              if (bytes_left_q == 8'd1) phase_d = PH_DONE;
            end
            PH_RESULT: begin
              phase_d = (rx_byte_i == cfg_i.write_ok) ? PH_DONE : PH_ERROR;
            end
            default: ;
          endcase
        end
        CMD_ARM_READ: begin
          is_read_d = 1'b1;
          phase_d   = PH_HEADER;
        end
        CMD_ARM_WRITE: begin
          is_read_d = 1'b0;
          phase_d   = PH_HEADER;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      is_read_q    <= 1'b0;
      bytes_left_q <= '0;
      write_pos_q  <= '0;
      store_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      is_read_q    <= is_read_d;
      bytes_left_q <= bytes_left_d;
      write_pos_q  <= write_pos_d;
      store_q      <= store_d;
    end
  end

  // unpack little-endian words from the store as it stands after this item
  assign status_d = status_of(phase_d, is_read_d);

  always_comb begin
    result_o.status = status_d;
    for (int k = 0; k < NUM_WORDS; k++) begin
      result_o.words[k] = (status_d == ST_READ_DONE) ?
                          {store_d[2*k+1], store_d[2*k]} : '0;
    end
  end

  a_last_byte_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && cmd_e'(cmd_i) == CMD_BYTE && phase_q == PH_DATA && bytes_left_q == 8'd1
    |=> phase_q == PH_DONE)
    else $error("last data byte did not finish the read");

  a_arm_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && cmd_e'(cmd_i) == CMD_ARM_READ |=> phase_q == PH_HEADER && is_read_q)
    else $error("arm read did not start a read transaction");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ERROR || phase_q == PH_DONE) && !(take_i && cmd_e'(cmd_i) == CMD_ARM_READ)
    && !(take_i && cmd_e'(cmd_i) == CMD_ARM_WRITE) |=> $stable(phase_q))
    else $error("done or error left without an arm");

endmodule

// File: rtl/imu_urp_outreg.sv
module imu_urp_outreg import imu_urp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    ready_i,
  output logic    valid_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // hold the item until taken
  always_ff @(posedge clk_i) begin
    if (load_i) result_q <= result_i;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// File: rtl/imu_uart_response_parser_core.sv
// channel  | dir | payload                                   | accepted when
// in_i     | in  | cmd, rx_byte                              | valid && ready
// cfg_i    | in  | index (register), data                    | valid && ready
// out_o    | out | status, gyro x/y/z, heading, roll, pitch, | valid && ready
//          |     | quat w/x/y/z                              |
//
// One item a cycle while in_i.ready is high; each item yields one result, valid in the cycle after it is accepted.
// The parser state and byte store update at the accepting edge; the result
// register is loaded in the same edge.
// Input ready drops only while a result sits unread and out_o.ready is low.
// Reset restores the default codes and clears state and the byte store.
// The configuration port is always ready.
module imu_uart_response_parser_core import imu_urp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  imu_urp_in_if.sink    in_i,
  imu_urp_cfg_if.sink   cfg_i,
  imu_urp_out_if.source out_o
);

  cfg_t    cfg;
  result_t result_d;
  result_t result_q;
  logic    take;
  logic    out_valid;

  assign in_i.ready = !out_valid || out_o.ready;
  assign take       = in_i.valid && in_i.ready;

  imu_urp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  imu_urp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .cmd_i     (in_i.cmd),
    .rx_byte_i (in_i.rx_byte),
    .cfg_i     (cfg),
    .result_o  (result_d)
  );

  imu_urp_outreg u_outreg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (take),
    .result_i (result_d),
    .ready_i  (out_o.ready),
    .valid_o  (out_valid),
    .result_o (result_q)
  );

  assign out_o.valid   = out_valid;
  assign out_o.status  = result_q.status;
  assign out_o.gyro_x  = $signed(result_q.words[0]);
  assign out_o.gyro_y  = $signed(result_q.words[1]);
  assign out_o.gyro_z  = $signed(result_q.words[2]);
  assign out_o.heading = $signed(result_q.words[3]);
  assign out_o.roll    = $signed(result_q.words[4]);
  assign out_o.pitch   = $signed(result_q.words[5]);
  assign out_o.quat_w  = $signed(result_q.words[6]);
  assign out_o.quat_x  = $signed(result_q.words[7]);
  assign out_o.quat_y  = $signed(result_q.words[8]);
  assign out_o.quat_z  = $signed(result_q.words[9]);

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while a result is stalled");

  a_words_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && result_q.status != ST_READ_DONE |-> result_q.words == '0)
    else $error("words not cleared outside read done");

  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid)
    else $error("accepted item produced no result");

endmodule
